// ===== rtl/core/dgcd_pkg.sv =====
// Shared types and field widths for the directed graph cycle detector.
`timescale 1ns / 1ps

package dgcd_pkg;

   // Fixed widths of the channel and register fields
   localparam int unsigned EDGE_W = 6;
   localparam int unsigned CNT_W  = 7;

   // Reset value of the vertex count register
   localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROOT,
      ST_READ,
      ST_EVAL,
      ST_POP,
      ST_REPORT
   } dgcd_state_type;

endpackage

// ===== rtl/core/directed_graph_cycle_detect.sv =====
// Top level of the directed graph cycle detector: edge loading and DFS controller.
`timescale 1ns / 1ps
//
// Usage:
//   req_* carries one directed edge per transfer (source, target, last flag).
//   An edge is stored into the adjacency RAM by a read-modify-write of its
//   source row, so a new edge is taken only once the last one is written. Edges
//   naming a vertex at or above min(csr_wr_data count, MAX_VERTICES) are dropped
//   and flagged.
//   The edge marked last starts a depth-first search over every vertex. Each
//   vertex costs a row read, one evaluate per child it pushes and one when it
//   pops, plus a pop step to fetch the parent from the stack RAM; the root
//   scan probes each vertex in turn. One path through every vertex is the worst
//   case.
//   rsp_* carries one result per graph (has_cycle, edge_dropped) out of an
//   output register; it holds while rsp_stall is high, and the search result
//   waits in the controller until the register is free. req_stall stays high
//   from an accepted edge until the block is back in its idle state.
//   Row valid bits, marks and the drop flag clear as the report's result is
//   registered. Reset clears all control state and sets the vertex count to 64.
//   csr_wr_en writes the vertex count; write it only while the block is idle.

module directed_graph_cycle_detect
   import dgcd_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = 64
) (
   input  logic              clock,
   input  logic              reset,
   // Configuration
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data,
   // Edge channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [EDGE_W-1:0] req_edge_src,
   input  logic [EDGE_W-1:0] req_edge_dst,
   input  logic              req_last_edge,
   // Result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_has_cycle,
   output logic              rsp_edge_dropped
);

   localparam int unsigned VW = $clog2(MAX_VERTICES);
   localparam int unsigned DW = $clog2(MAX_VERTICES + 1);
   localparam int unsigned CW = (DW > CNT_W) ? DW : CNT_W;
   localparam logic [MAX_VERTICES-1:0] ONE_VEC = MAX_VERTICES'(1);

   dgcd_state_type state_ff, state_in;

   logic [CNT_W-1:0]        num_vertices_ff;
   logic [VW-1:0]           src_ff, src_in;
   logic [VW-1:0]           dst_ff, dst_in;
   logic                    last_ff, last_in;
   logic                    keep_ff, keep_in;
   logic                    drop_ff, drop_in;
   logic                    cyc_ff, cyc_in;
   logic [MAX_VERTICES-1:0] row_valid_ff, row_valid_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [MAX_VERTICES-1:0] onpath_ff, onpath_in;
   logic [DW-1:0]           depth_ff, depth_in;
   logic [DW-1:0]           root_ff, root_in;
   logic [VW-1:0]           top_ff, top_in;
   logic                    rd_valid_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_has_cycle_ff, rsp_has_cycle_in;
   logic                    rsp_edge_dropped_ff, rsp_edge_dropped_in;

   logic                    adj_wr_en;
   logic [VW-1:0]           adj_wr_addr;
   logic [MAX_VERTICES-1:0] adj_wr_data;
   logic [VW-1:0]           adj_rd_addr;
   logic [MAX_VERTICES-1:0] adj_rd_data;

   logic                    stk_wr_en;
   logic [VW-1:0]           stk_wr_addr;
   logic [VW-1:0]           stk_wr_data;
   logic [VW-1:0]           stk_rd_addr;
   logic [VW-1:0]           stk_rd_data;

   logic [CW-1:0]           count_eff;
   logic [CW-1:0]           src_ext;
   logic [CW-1:0]           dst_ext;
   logic [MAX_VERTICES-1:0] row;
   logic [MAX_VERTICES-1:0] cand;
   logic                    found;
   logic [VW-1:0]           next_w;
   logic [DW-1:0]           depth_m2;
   logic [VW-1:0]           root_idx;
   logic                    root_done;

   // Adjacency rows, one per source vertex
   dgcd_ram #(
      .WIDTH (MAX_VERTICES),
      .DEPTH (MAX_VERTICES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   // DFS vertex stack
   dgcd_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_VERTICES)
   ) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // Effective vertex count and range check of the incoming edge
   assign count_eff = (CW'(num_vertices_ff) > CW'(MAX_VERTICES)) ?
                      CW'(MAX_VERTICES) : CW'(num_vertices_ff);
   assign src_ext   = CW'(req_edge_src);
   assign dst_ext   = CW'(req_edge_dst);

   // Row as read, with never-written rows reading as zero
   assign row  = rd_valid_ff ? adj_rd_data : '0;
   assign cand = row & ~visited_ff;

   // Lowest unvisited successor
   always_comb begin
      found  = 1'b0;
      next_w = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            found  = 1'b1;
            next_w = VW'(i);
         end
      end
   end

   assign depth_m2  = depth_ff - DW'(2);
   assign root_idx  = root_ff[VW-1:0];
   assign root_done = (root_ff == DW'(MAX_VERTICES));

   // Next state, datapath updates and memory controls
   always_comb begin
      state_in            = state_ff;
      src_in              = src_ff;
      dst_in              = dst_ff;
      last_in             = last_ff;
      keep_in             = keep_ff;
      drop_in             = drop_ff;
      cyc_in              = cyc_ff;
      row_valid_in        = row_valid_ff;
      visited_in          = visited_ff;
      onpath_in           = onpath_ff;
      depth_in            = depth_ff;
      root_in             = root_ff;
      top_in              = top_ff;
      rsp_has_cycle_in    = rsp_has_cycle_ff;
      rsp_edge_dropped_in = rsp_edge_dropped_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;

      adj_wr_en   = 1'b0;
      adj_wr_addr = src_ff;
      adj_wr_data = row | (ONE_VEC << dst_ff);
      adj_rd_addr = top_ff;
      stk_wr_en   = 1'b0;
      stk_wr_addr = depth_ff[VW-1:0];
      stk_wr_data = top_ff;
      stk_rd_addr = depth_m2[VW-1:0];

      case (state_ff)
         ST_IDLE: begin
            // Read the source row as the edge transfers
            adj_rd_addr = src_ext[VW-1:0];
            if (req_valid) begin
               src_in   = src_ext[VW-1:0];
               dst_in   = dst_ext[VW-1:0];
               last_in  = req_last_edge;
               keep_in  = (src_ext < count_eff) && (dst_ext < count_eff);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Merge the target bit into the row, or flag the drop
            if (keep_ff) begin
               adj_wr_en            = 1'b1;
               row_valid_in[src_ff] = 1'b1;
            end else begin
               drop_in = 1'b1;
            end
            if (last_ff) begin
               root_in  = '0;
               cyc_in   = 1'b0;
               state_in = ST_ROOT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ROOT: begin
            // Probe the next root; push it when unvisited
            if (root_done) begin
               state_in = ST_REPORT;
            end else if (visited_ff[root_idx]) begin
               root_in = root_ff + DW'(1);
            end else begin
               stk_wr_en             = 1'b1;
               stk_wr_data           = root_idx;
               depth_in              = depth_ff + DW'(1);
               visited_in[root_idx]  = 1'b1;
               onpath_in[root_idx]   = 1'b1;
               top_in                = root_idx;
               root_in               = root_ff + DW'(1);
               state_in              = ST_READ;
            end
         end
         ST_READ: begin
            adj_rd_addr = top_ff;
            state_in    = ST_EVAL;
         end
         ST_EVAL: begin
            if ((row & onpath_ff) != '0) begin
               // Back edge to the current path closes a cycle
               cyc_in   = 1'b1;
               state_in = ST_REPORT;
            end else if (found) begin
               // Descend into the lowest unvisited successor
               stk_wr_en          = 1'b1;
               stk_wr_data        = next_w;
               depth_in           = depth_ff + DW'(1);
               visited_in[next_w] = 1'b1;
               onpath_in[next_w]  = 1'b1;
               top_in             = next_w;
               state_in           = ST_READ;
            end else begin
               // Drop the finished vertex from the path
               onpath_in[top_ff] = 1'b0;
               depth_in          = depth_ff - DW'(1);
               if (depth_ff == DW'(1)) begin
                  state_in = ST_ROOT;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            // New top comes from the stack; fetch its row at once
            top_in      = stk_rd_data;
            adj_rd_addr = stk_rd_data;
            state_in    = ST_EVAL;
         end
         ST_REPORT: begin
            // Hand the result to the output register and clear the graph
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_has_cycle_in    = cyc_ff;
               rsp_edge_dropped_in = drop_ff;
               row_valid_in        = '0;
               visited_in          = '0;
               onpath_in           = '0;
               depth_in            = '0;
               drop_in             = 1'b0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         num_vertices_ff <= CNT_RESET;
         drop_ff         <= 1'b0;
         cyc_ff          <= 1'b0;
         row_valid_ff    <= '0;
         visited_ff      <= '0;
         onpath_ff       <= '0;
         depth_ff        <= '0;
         root_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         if (csr_wr_en) begin
            num_vertices_ff <= csr_wr_data;
         end
         drop_ff         <= drop_in;
         cyc_ff          <= cyc_in;
         row_valid_ff    <= row_valid_in;
         visited_ff      <= visited_in;
         onpath_ff       <= onpath_in;
         depth_ff        <= depth_in;
         root_ff         <= root_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      src_ff              <= src_in;
      dst_ff              <= dst_in;
      last_ff             <= last_in;
      keep_ff             <= keep_in;
      top_ff              <= top_in;
      rd_valid_ff         <= row_valid_ff[adj_rd_addr];
      rsp_has_cycle_ff    <= rsp_has_cycle_in;
      rsp_edge_dropped_ff <= rsp_edge_dropped_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_has_cycle    = rsp_has_cycle_ff;
   assign rsp_edge_dropped = rsp_edge_dropped_ff;

endmodule

// ===== rtl/core/dgcd_ram.sv =====
// Simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module dgcd_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/directed_graph_cycle_detect_tb.sv =====
// Testbench for the directed graph cycle detector: edge stimulus, cycle prediction, result check.
`timescale 1ns / 1ps

module directed_graph_cycle_detect_tb
   import dgcd_pkg::*;
();

   localparam int unsigned NUM_V           = 64;
   localparam int unsigned N_PHASES        = 9;
   localparam int unsigned ITEMS_PER_PHASE = 180;
   // worst-case search plus slack, used before a count write and at the end
   localparam int unsigned SEARCH_CYCLES   = 6 * NUM_V;
   localparam longint unsigned LIMIT_CYCLES = 2_000_000;
   localparam int unsigned PHASE_COUNT [N_PHASES] = '{64, 1, 0, 127, 12, 64, 2, 65, 40};

   typedef struct packed {
      logic [EDGE_W-1:0] src;
      logic [EDGE_W-1:0] dst;
      logic              last;
   } edge_item_type;

   typedef struct packed {
      logic has_cycle;
      logic edge_dropped;
   } verdict_type;

   // DUT signals
   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              csr_wr_en        = 1'b0;
   logic [CNT_W-1:0]  csr_wr_data      = CNT_RESET;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [EDGE_W-1:0] req_edge_src     = '0;
   logic [EDGE_W-1:0] req_edge_dst     = '0;
   logic              req_last_edge    = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic              rsp_has_cycle;
   logic              rsp_edge_dropped;

   // Stimulus and scoreboard state
   edge_item_type     edge_queue [$];
   verdict_type       expected_verdicts [$];
   int                edges_outstanding = 0;
   int unsigned       items_queued      = 0;
   int unsigned       send_idle_pct     = 0;
   int unsigned       stall_pct         = 0;
   logic              edge_taken        = 1'b0;
   int unsigned       mismatch_count    = 0;
   int unsigned       result_index      = 0;
   longint unsigned   cycle_count       = 0;

   // Predictor state: adjacency matrix, drop flag and vertex count
   logic [NUM_V-1:0]  adj_rows [NUM_V];
   logic              graph_dropped     = 1'b0;
   logic [CNT_W-1:0]  vertex_count      = CNT_RESET;

   directed_graph_cycle_detect #(
      .MAX_VERTICES(NUM_V)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_edge_src     (req_edge_src),
      .req_edge_dst     (req_edge_dst),
      .req_last_edge    (req_last_edge),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_has_cycle    (rsp_has_cycle),
      .rsp_edge_dropped (rsp_edge_dropped)
   );

   always #10 clock = ~clock;

   initial begin
      for (int unsigned i = 0; i < NUM_V; i++) begin
         adj_rows[i] = '0;
      end
   end

   // Iterative DFS over every root; any edge back onto the current path closes a cycle
   function automatic logic graph_has_cycle();
      logic [NUM_V-1:0] visited;
      logic [NUM_V-1:0] on_path;
      logic [NUM_V-1:0] open_succ;
      int unsigned      dfs_stack [NUM_V];
      int unsigned      depth;
      int unsigned      v;
      int unsigned      w;
      visited = '0;
      on_path = '0;
      depth   = 0;
      for (int unsigned root = 0; root < NUM_V; root++) begin
         if (!visited[root]) begin
            dfs_stack[0]  = root;
            depth         = 1;
            visited[root] = 1'b1;
            on_path[root] = 1'b1;
            while (depth > 0) begin
               v = dfs_stack[depth-1];
               if ((adj_rows[v] & on_path) != '0) begin
                  return 1'b1;
               end
               open_succ = adj_rows[v] & ~visited;
               if (open_succ != '0) begin
                  // descend into the lowest unvisited successor
                  w = 0;
                  while (!open_succ[w]) w++;
                  dfs_stack[depth] = w;
                  depth++;
                  visited[w] = 1'b1;
                  on_path[w] = 1'b1;
               end else begin
                  depth--;
                  on_path[v] = 1'b0;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   // Store one accepted edge; on the last edge, predict the verdict and clear the graph
   task automatic store_edge(input edge_item_type e);
      int unsigned eff_count;
      verdict_type verdict;
      eff_count = (vertex_count > NUM_V) ? NUM_V : vertex_count;
      if (e.src < eff_count && e.dst < eff_count) begin
         adj_rows[e.src][e.dst] = 1'b1;
      end else begin
         graph_dropped = 1'b1;
      end
      if (e.last) begin
         verdict.has_cycle    = graph_has_cycle();
         verdict.edge_dropped = graph_dropped;
         expected_verdicts.insert(expected_verdicts.size(), verdict);
         for (int unsigned i = 0; i < NUM_V; i++) begin
            adj_rows[i] = '0;
         end
         graph_dropped = 1'b0;
      end
   endtask

   task automatic push_edge(input logic [EDGE_W-1:0] src, input logic [EDGE_W-1:0] dst,
                            input logic last);
      edge_item_type item;
      item.src  = src;
      item.dst  = dst;
      item.last = last;
      edge_queue.insert(edge_queue.size(), item);
      edges_outstanding++;
      items_queued++;
   endtask

   // Hand-picked graphs: self loops, extreme vertices, short cycles, drops, count change
   task automatic queue_directed(input int unsigned phase);
      case (phase)
         0: begin
            push_edge(6'd0, 6'd0, 1'b1);
            push_edge(6'd63, 6'd63, 1'b1);
            push_edge(6'd0, 6'd1, 1'b0);
            push_edge(6'd1, 6'd2, 1'b0);
            push_edge(6'd2, 6'd0, 1'b1);
            push_edge(6'd0, 6'd1, 1'b0);
            push_edge(6'd1, 6'd2, 1'b1);
            push_edge(6'd63, 6'd0, 1'b0);
            push_edge(6'd0, 6'd63, 1'b1);
            push_edge(6'd5, 6'd6, 1'b0);
            push_edge(6'd5, 6'd7, 1'b0);
            push_edge(6'd6, 6'd7, 1'b1);
         end
         1: begin
            push_edge(6'd0, 6'd0, 1'b1);
            push_edge(6'd0, 6'd1, 1'b0);
            push_edge(6'd0, 6'd0, 1'b1);
            push_edge(6'd1, 6'd0, 1'b1);
         end
         2: begin
            push_edge(6'd0, 6'd0, 1'b1);
            push_edge(6'd63, 6'd63, 1'b1);
         end
         3: begin
            push_edge(6'd63, 6'd62, 1'b0);
            push_edge(6'd62, 6'd63, 1'b1);
         end
         // closes a cycle with the edge left pending under the previous count
         4: begin
            push_edge(6'd11, 6'd10, 1'b1);
         end
         default: begin
         end
      endcase
   endtask

   // One random graph: ranked (acyclic but for a one-vertex self loop), chain with optional back edge, random, or noisy
   task automatic queue_random_graph(input int unsigned eff);
      int unsigned   perm [NUM_V];
      edge_item_type graph_edges [$];
      edge_item_type e;
      int unsigned   kind;
      int unsigned   m;
      int unsigned   n_edges;
      int unsigned   a;
      int unsigned   b;
      int unsigned   j;
      int unsigned   tmp;
      for (int unsigned i = 0; i < NUM_V; i++) begin
         perm[i] = (eff == 0) ? $urandom_range(0, NUM_V - 1) : i;
      end
      for (int unsigned i = eff; i > 1; i--) begin
         j           = $urandom_range(0, i - 1);
         tmp         = perm[i-1];
         perm[i-1]   = perm[j];
         perm[j]     = tmp;
      end
      if (eff == 0) begin
         m = $urandom_range(1, 4);
      end else if ($urandom_range(0, 7) == 0) begin
         m = eff;
      end else begin
         m = $urandom_range(1, (eff < 10) ? eff : 10);
      end
      e.last = 1'b0;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         // edges only from lower to higher rank, or a self loop when there is a single vertex
         n_edges = $urandom_range(1, 2 * m);
         repeat (n_edges) begin
            a = $urandom_range(0, m - 1);
            b = $urandom_range(0, m - 1);
            if (a > b) begin
               tmp = a;
               a   = b;
               b   = tmp;
            end
            if (a != b || m == 1) begin
               e.src = EDGE_W'(perm[a]);
               e.dst = EDGE_W'(perm[b]);
               graph_edges.insert(graph_edges.size(), e);
            end
         end
      end else if (kind < 6) begin
         // long path, deep stack
         for (int unsigned i = 0; i + 1 < m; i++) begin
            e.src = EDGE_W'(perm[i]);
            e.dst = EDGE_W'(perm[i+1]);
            graph_edges.insert(graph_edges.size(), e);
         end
         if ($urandom_range(0, 1) == 1) begin
            a = $urandom_range(0, m - 1);
            b = $urandom_range(a, m - 1);
            e.src = EDGE_W'(perm[b]);
            e.dst = EDGE_W'(perm[a]);
            graph_edges.insert(graph_edges.size(), e);
         end
      end else begin
         n_edges = $urandom_range(1, 3 * m);
         repeat (n_edges) begin
            if (kind >= 8 && $urandom_range(0, 3) == 0) begin
               e.src = EDGE_W'($urandom_range(0, NUM_V - 1));
               e.dst = EDGE_W'($urandom_range(0, NUM_V - 1));
            end else begin
               e.src = EDGE_W'(perm[$urandom_range(0, m - 1)]);
               e.dst = EDGE_W'(perm[$urandom_range(0, m - 1)]);
            end
            e.last = 1'b0;
            graph_edges.insert(graph_edges.size(), e);
         end
      end
      if (graph_edges.size() == 0) begin
         e.src  = EDGE_W'(perm[0]);
         e.dst  = EDGE_W'(perm[m-1]);
         e.last = 1'b0;
         graph_edges.insert(graph_edges.size(), e);
      end
      // shuffle edge order
      for (int i = graph_edges.size() - 1; i > 0; i--) begin
         j              = $urandom_range(0, i);
         e              = graph_edges[i];
         graph_edges[i] = graph_edges[j];
         graph_edges[j] = e;
      end
      foreach (graph_edges[i]) begin
         push_edge(graph_edges[i].src, graph_edges[i].dst, i == graph_edges.size() - 1);
      end
   endtask

   task automatic write_count(input logic [CNT_W-1:0] value);
      @(negedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= value;
      vertex_count  = value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   // Hold until every edge is taken and every verdict has come, then let the search settle
   task automatic wait_idle();
      @(negedge clock);
      while (edges_outstanding != 0 || expected_verdicts.size() != 0) begin
         @(negedge clock);
      end
      repeat (SEARCH_CYCLES) @(negedge clock);
   endtask

   // Edge driver and receiver stall, both at the falling edge
   always @(negedge clock) begin : edge_driver
      edge_item_type next_edge;
      if (!reset && (!req_valid || edge_taken)) begin
         if (edge_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_edge      = edge_queue.pop_front();
            req_valid     <= 1'b1;
            req_edge_src  <= next_edge.src;
            req_edge_dst  <= next_edge.dst;
            req_last_edge <= next_edge.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Monitor: predict on each edge transfer, check each result transfer
   always @(posedge clock) begin : verdict_monitor
      verdict_type want;
      if (reset) begin
         edge_taken <= 1'b0;
      end else begin
         edge_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            store_edge('{src: req_edge_src, dst: req_edge_dst, last: req_last_edge});
            edges_outstanding--;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result %0d: has_cycle=%b edge_dropped=%b",
                           result_index, rsp_has_cycle, rsp_edge_dropped);
               end
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_has_cycle !== want.has_cycle ||
                   rsp_edge_dropped !== want.edge_dropped) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result %0d: has_cycle exp %b got %b, edge_dropped exp %b got %b",
                              result_index, want.has_cycle, rsp_has_cycle,
                              want.edge_dropped, rsp_edge_dropped);
                  end
               end
            end
            result_index++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("directed_graph_cycle_detect_tb: FAIL");
         $finish;
      end
   end

   // Sequence: reset, then one phase per vertex count setting
   initial begin
      int unsigned eff;
      int unsigned phase_start;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int unsigned p = 0; p < N_PHASES; p++) begin
         send_idle_pct = (p < 3) ? 33 : (p < 6) ? 51 : 0;
         stall_pct     = (p < 3) ? 51 : (p < 6) ? 33 : 0;
         write_count(CNT_W'(PHASE_COUNT[p]));
         queue_directed(p);
         eff         = (PHASE_COUNT[p] > NUM_V) ? NUM_V : PHASE_COUNT[p];
         phase_start = items_queued;
         while (items_queued - phase_start < ITEMS_PER_PHASE) begin
            queue_random_graph(eff);
         end
         // leave a graph half loaded across the next count change
         if (p == 3) begin
            push_edge(6'd10, 6'd11, 1'b0);
         end
         wait_idle();
      end
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("directed_graph_cycle_detect_tb: PASS");
      end else begin
         $display("directed_graph_cycle_detect_tb: FAIL");
      end
      $finish;
   end

endmodule
